// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define JET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// precondition at one edge implies the outcome at the next edge
`define JET_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/jet_pkg.sv =====
`default_nettype none

package jet_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int ITER_W         = 16;
  localparam int CFG_ADDR_W     = 8;

  localparam logic [ITER_W-1:0] ITER_CAP_RESET = 16'd256;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ITER_CAP = 8'd0,
    REG_C_REAL   = 8'd1,
    REG_C_IMAG   = 8'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mag_esc;
    logic rng_esc;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/julia_escape_time_top.sv =====
// Julia set escape time: each input transaction carries one start point z0, and the block
// repeats z = z*z + c with the configured constant c, returning the index of the first
// update whose squared magnitude exceeds 4 or whose real or imaginary part leaves [-2, 2]
// (escaped = 1), or the iteration limit (escaped = 0). Each update runs in order: three
// parallel products of z are registered, then the update, range check and magnitude check
// of the previous update follow. A result still waiting in the output register holds the
// block in its finish state.
// A new item is taken once the previous result sits in the output register.
`default_nettype none

module julia_escape_time_top #(
  parameter int WORD_WIDTH = jet_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = jet_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // z0_real, z0_imag
  input  logic [((2*WORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // iterations
  output logic [jet_pkg::ITER_W-1:0]              out_tdata,
  // escaped
  output logic                                    out_tuser,
  input  logic                                    cfg_we,
  input  logic [jet_pkg::CFG_ADDR_W-1:0]          cfg_addr,
  input  logic [((WORD_WIDTH > jet_pkg::ITER_W) ? WORD_WIDTH : jet_pkg::ITER_W)-1:0] cfg_wdata
);

  logic [jet_pkg::ITER_W-1:0] iter_cap_r;
  logic [WORD_WIDTH-1:0]      c_real_r, c_imag_r;

  jet_pkg::cmd_t cmd;
  jet_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_cap_r <= jet_pkg::ITER_CAP_RESET;
      c_real_r   <= '0;
      c_imag_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        jet_pkg::REG_ITER_CAP: iter_cap_r <= cfg_wdata[jet_pkg::ITER_W-1:0];
        jet_pkg::REG_C_REAL:   c_real_r   <= cfg_wdata[WORD_WIDTH-1:0];
        jet_pkg::REG_C_IMAG:   c_imag_r   <= cfg_wdata[WORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  jet_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_iter   (out_tdata),
    .out_esc    (out_tuser),
    .iter_cap   (iter_cap_r),
    .cmd        (cmd),
    .sts        (sts)
  );

  jet_datapath #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk    (clk),
    .in_re  (in_tdata[WORD_WIDTH-1:0]),
    .in_im  (in_tdata[2*WORD_WIDTH-1:WORD_WIDTH]),
    .c_real (c_real_r),
    .c_imag (c_imag_r),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/jet_datapath.sv =====
`default_nettype none

module jet_datapath #(
  parameter int WORD_WIDTH = jet_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = jet_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [WORD_WIDTH-1:0] in_re,
  input  logic signed [WORD_WIDTH-1:0] in_im,
  input  logic signed [WORD_WIDTH-1:0] c_real,
  input  logic signed [WORD_WIDTH-1:0] c_imag,
  input  jet_pkg::cmd_t                cmd,
  output jet_pkg::sts_t                sts
);

  // z register must hold a start word and any value in [-2, 2]
  localparam int ZW = (WORD_WIDTH > FRAC_BITS + 3) ? WORD_WIDTH : FRAC_BITS + 3;
  localparam int MW = 2 * ZW;
  localparam int PW = 2 * ZW + 2;

  localparam logic signed [PW-1:0] LIM  = PW'(1) << (FRAC_BITS + 1);
  localparam logic signed [PW-1:0] NLIM = -LIM;
  localparam logic signed [PW-1:0] FOUR = PW'(1) << (2 * FRAC_BITS + 2);

  logic signed [ZW-1:0] z_re_r, z_im_r;
  logic signed [MW-1:0] p_rr_r, p_ii_r, p_ri_r;
  logic signed [MW-1:0] p_rr_nxt, p_ii_nxt, p_ri_nxt;
  logic signed [PW-1:0] re_diff, re_new, im_new, mag;

  assign p_rr_nxt = MW'(z_re_r) * MW'(z_re_r);
  assign p_ii_nxt = MW'(z_im_r) * MW'(z_im_r);
  assign p_ri_nxt = MW'(z_re_r) * MW'(z_im_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_rr_r <= p_rr_nxt;
      p_ii_r <= p_ii_nxt;
      p_ri_r <= p_ri_nxt;
    end
  end

  // update from registered products, floor shifts, exact width
  assign re_diff = PW'(p_rr_r) - PW'(p_ii_r);
  assign re_new  = (re_diff >>> FRAC_BITS) + PW'(c_real);
  assign im_new  = (PW'(p_ri_r) >>> (FRAC_BITS - 1)) + PW'(c_imag);

  // squares of the current z are the magnitude of the previous update
  assign mag = PW'(p_rr_r) + PW'(p_ii_r);

  assign sts.rng_esc = (re_new > LIM) || (re_new < NLIM) || (im_new > LIM) || (im_new < NLIM);
  assign sts.mag_esc = mag > FOUR;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_re_r <= ZW'(in_re);
      z_im_r <= ZW'(in_im);
    end else if (cmd.step) begin
      z_re_r <= re_new[ZW-1:0];
      z_im_r <= im_new[ZW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jet_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module jet_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [jet_pkg::ITER_W-1:0]   out_iter,
  output logic                         out_esc,
  input  logic [jet_pkg::ITER_W-1:0]   iter_cap,
  output jet_pkg::cmd_t                cmd,
  input  jet_pkg::sts_t                sts
);

  jet_pkg::state_t state_r, state_nxt;

  logic [jet_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic [jet_pkg::ITER_W-1:0] pend_iter_r, pend_iter_nxt;
  logic                       pend_esc_r, pend_esc_nxt;
  logic [jet_pkg::ITER_W-1:0] out_iter_r, out_iter_nxt;
  logic                       out_esc_r, out_esc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       fin_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jet_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    pend_iter_r <= pend_iter_nxt;
    pend_esc_r  <= pend_esc_nxt;
    out_iter_r  <= out_iter_nxt;
    out_esc_r   <= out_esc_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_iter_nxt = pend_iter_r;
    pend_esc_nxt  = pend_esc_r;
    out_iter_nxt  = out_iter_r;
    out_esc_nxt   = out_esc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    fin_wr        = 1'b0;
    unique case (state_r)
      jet_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          if (iter_cap == '0) begin
            pend_iter_nxt = '0;
            pend_esc_nxt  = 1'b0;
            state_nxt     = jet_pkg::ST_FIN;
          end else begin
            state_nxt = jet_pkg::ST_MUL;
          end
        end
      end
      jet_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = jet_pkg::ST_UPD;
      end
      jet_pkg::ST_UPD: begin
        if ((cnt_r != '0) && sts.mag_esc) begin
          pend_iter_nxt = cnt_r - 1'b1;
          pend_esc_nxt  = 1'b1;
          state_nxt     = jet_pkg::ST_FIN;
        end else if (cnt_r == iter_cap) begin
          pend_iter_nxt = iter_cap;
          pend_esc_nxt  = 1'b0;
          state_nxt     = jet_pkg::ST_FIN;
        end else if (sts.rng_esc) begin
          pend_iter_nxt = cnt_r;
          pend_esc_nxt  = 1'b1;
          state_nxt     = jet_pkg::ST_FIN;
        end else begin
          cmd.step  = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = jet_pkg::ST_MUL;
        end
      end
      jet_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          fin_wr        = 1'b1;
          out_iter_nxt  = pend_iter_r;
          out_esc_nxt   = pend_esc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = jet_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jet_pkg::ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == jet_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_iter   = out_iter_r;
  assign out_esc    = out_esc_r;

  `JET_ASSERT_NEXT(a_load_next, cmd.load, state_r == jet_pkg::ST_MUL || state_r == jet_pkg::ST_FIN, "load not followed by multiply or finish")
  `JET_ASSERT_NEXT(a_mul_next, state_r == jet_pkg::ST_MUL, state_r == jet_pkg::ST_UPD, "multiply not followed by update")
  `JET_ASSERT(a_cnt_range, (state_r == jet_pkg::ST_MUL || state_r == jet_pkg::ST_UPD) |-> (cnt_r <= iter_cap), "iteration count beyond limit")
  `JET_ASSERT(a_esc_below, (fin_wr && pend_esc_r) |-> (pend_iter_r < iter_cap), "escape index not below limit")

endmodule

`default_nettype wire

// ===== dv/julia_escape_time_top_tb.sv =====
`default_nettype none

module julia_escape_time_top_tb;

  localparam int WORD_W = jet_pkg::WORD_WIDTH_DEF;
  localparam int FRAC = jet_pkg::FRAC_BITS_DEF;
  localparam int ITER_W = jet_pkg::ITER_W;
  localparam int CFG_ADDR_W = jet_pkg::CFG_ADDR_W;
  localparam int DATA_W = ((2 * WORD_W + 7) / 8) * 8;
  localparam int CFG_W = (WORD_W > ITER_W) ? WORD_W : ITER_W;

  localparam logic signed [127:0] ESC_LIM = 128'sd1 <<< (FRAC + 1);
  localparam logic signed [127:0] MAG_LIM = 128'sd1 <<< (2 * FRAC + 2);

  localparam logic [WORD_W-1:0] Q_ONE = 32'h1000_0000;
  localparam logic [WORD_W-1:0] Q_HALF = 32'h0800_0000;
  localparam logic [WORD_W-1:0] Q_TWO = 32'h2000_0000;
  localparam logic [WORD_W-1:0] Q_NEG_TWO = 32'hE000_0000;
  localparam logic [WORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] Q_SPAN = 32'h4000_0000;

  localparam logic signed [WORD_W-1:0] C_DENDRITE_RE = -32'sd214748365;
  localparam logic signed [WORD_W-1:0] C_DENDRITE_IM = 32'sd41875931;
  localparam logic signed [WORD_W-1:0] C_SPIRAL_RE = -32'sd107374182;
  localparam logic signed [WORD_W-1:0] C_SPIRAL_IM = 32'sd161061274;
  localparam logic signed [WORD_W-1:0] C_DUST_RE = 32'sd76504105;
  localparam logic signed [WORD_W-1:0] C_DUST_IM = 32'sd2684355;
  localparam logic signed [WORD_W-1:0] C_SWIRL_RE = -32'sd188377266;
  localparam logic signed [WORD_W-1:0] C_SWIRL_IM = -32'sd103132902;

  localparam logic [CFG_ADDR_W-1:0] BAD_REG_NEXT = 8'd3;
  localparam logic [CFG_ADDR_W-1:0] BAD_REG_TOP = 8'hFF;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS = 105;

  typedef enum int {
    PACE_FREE,
    PACE_TX_IDLE,
    PACE_RX_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct {
    logic [WORD_W-1:0] z_re;
    logic [WORD_W-1:0] z_im;
    logic [ITER_W-1:0] iters;
    logic              esc;
  } escape_rec_t;

  class escape_sb;
    escape_rec_t       pending[$];
    logic [ITER_W-1:0] iter_limit;
    logic [WORD_W-1:0] c_re;
    logic [WORD_W-1:0] c_im;
    int                n_points;
    int                n_escaped;
    int                n_bad;

    function new();
      iter_limit = jet_pkg::ITER_CAP_RESET;
      c_re = '0;
      c_im = '0;
      n_points = 0;
      n_escaped = 0;
      n_bad = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
      case (addr)
        jet_pkg::REG_ITER_CAP: iter_limit = data[ITER_W-1:0];
        jet_pkg::REG_C_REAL: c_re = data[WORD_W-1:0];
        jet_pkg::REG_C_IMAG: c_im = data[WORD_W-1:0];
        default: ;
      endcase
    endfunction

    function escape_rec_t escape_count(logic [WORD_W-1:0] z_re, logic [WORD_W-1:0] z_im);
      escape_rec_t       r;
      logic signed [127:0] zr, zi, nr, ni, cr, ci, mag;
      r.z_re = z_re;
      r.z_im = z_im;
      r.iters = iter_limit;
      r.esc = 1'b0;
      zr = {{(128 - WORD_W){z_re[WORD_W-1]}}, z_re};
      zi = {{(128 - WORD_W){z_im[WORD_W-1]}}, z_im};
      cr = {{(128 - WORD_W){c_re[WORD_W-1]}}, c_re};
      ci = {{(128 - WORD_W){c_im[WORD_W-1]}}, c_im};
      for (int i = 0; i < int'(iter_limit); i++) begin
        nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
        ni = ((zr * zi) >>> (FRAC - 1)) + ci;
        if (nr > ESC_LIM || nr < -ESC_LIM || ni > ESC_LIM || ni < -ESC_LIM) begin
          r.iters = i[ITER_W-1:0];
          r.esc = 1'b1;
          return r;
        end
        zr = nr;
        zi = ni;
        mag = zr * zr + zi * zi;
        if (mag > MAG_LIM) begin
          r.iters = i[ITER_W-1:0];
          r.esc = 1'b1;
          return r;
        end
      end
      return r;
    endfunction

    function void note_point(logic [WORD_W-1:0] z_re, logic [WORD_W-1:0] z_im);
      escape_rec_t r;
      r = escape_count(z_re, z_im);
      n_points++;
      if (r.esc) n_escaped++;
      pending.push_back(r);
    endfunction

    function void check_result(logic [ITER_W-1:0] iters, logic esc);
      escape_rec_t r;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: result with none pending, iterations %0d escaped %0d",
                   iters, esc);
        return;
      end
      r = pending.pop_front();
      if (iters !== r.iters || esc !== r.esc) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: z0 %h/%h iterations exp %0d got %0d, escaped exp %0d got %0d",
                   r.z_re, r.z_im, r.iters, iters, r.esc, esc);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [ITER_W-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  escape_sb sb;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;
  bit       hold_req = 1'b0;
  int       n_settings = 0;

  julia_escape_time_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_point(in_tdata[WORD_W-1:0], in_tdata[2*WORD_W-1:WORD_W]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // receiver side, with a one-off long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [WORD_W-1:0] rand_in_disk();
    return $urandom_range(0, Q_SPAN) - Q_TWO;
  endfunction

  function automatic logic [WORD_W-1:0] edge_value();
    case ($urandom_range(0, 5))
      0: return Q_TWO;
      1: return Q_NEG_TWO;
      2: return '0;
      3: return Q_ONE;
      4: return Q_MIN;
      default: return Q_MAX;
    endcase
  endfunction

  function automatic logic [2*WORD_W-1:0] pick_point();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return {rand_in_disk(), rand_in_disk()};
    else if (sel < 88) return {edge_value(), rand_in_disk()};
    else return {$urandom(), $urandom()};
  endfunction

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FREE: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      PACE_TX_IDLE: begin
        tx_idle_pct = 68;
        rx_stall_pct = 0;
      end
      PACE_RX_STALL: begin
        tx_idle_pct = 0;
        rx_stall_pct = 68;
      end
      default: begin
        tx_idle_pct = 16;
        rx_stall_pct = 16;
      end
    endcase
  endtask

  task automatic send_point(input logic [WORD_W-1:0] z_re, input logic [WORD_W-1:0] z_im);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= DATA_W'({z_im, z_re});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(addr, data);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] lim, input logic [WORD_W-1:0] cr,
                              input logic [WORD_W-1:0] ci);
    write_reg(jet_pkg::REG_ITER_CAP, lim);
    write_reg(jet_pkg::REG_C_REAL, cr);
    write_reg(jet_pkg::REG_C_IMAG, ci);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] lim, input logic [WORD_W-1:0] cr,
                           input logic [WORD_W-1:0] ci, input pace_t pace, input bit with_hold);
    logic [2*WORD_W-1:0] p;
    wait_idle();
    apply_config(lim, cr, ci);
    set_pace(pace);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (with_hold && k == PHASE_ITEMS / 5) hold_req = 1'b1;
      p = pick_point();
      send_point(p[WORD_W-1:0], p[2*WORD_W-1:WORD_W]);
    end
  endtask

  initial begin
    sb = new();
    n_settings = 1;
    set_pace(PACE_FREE);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: limit 256, c = 0
    send_point('0, '0);
    send_point(Q_TWO, '0);
    send_point(Q_NEG_TWO, '0);
    send_point('0, Q_TWO);
    send_point(Q_ONE, '0);
    send_point('0, Q_ONE);
    send_point(Q_MAX, Q_MAX);
    send_point(Q_MIN, Q_MIN);
    send_point(Q_MIN, Q_MAX);
    send_point(Q_MAX, '0);
    send_point(Q_HALF, Q_HALF);
    send_point(32'h0000_0001, 32'hFFFF_FFFF);
    send_point(32'h1000_1000, '0);

    // writes to unused indexes must leave the settings alone
    wait_idle();
    write_reg(BAD_REG_NEXT, 32'h0000_0001);
    write_reg(BAD_REG_TOP, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    send_point(32'h1100_0000, '0);

    wait_idle();
    apply_config(32'd0, '0, '0);
    send_point('0, '0);
    send_point(Q_MAX, Q_MIN);

    wait_idle();
    apply_config(32'd1, Q_ONE, Q_NEG_TWO);
    send_point(Q_HALF, '0);
    send_point(Q_TWO, Q_TWO);

    wait_idle();
    apply_config(32'd65535, '0, '0);
    send_point('0, '0);

    wait_idle();
    apply_config(32'd65535, Q_MIN, Q_MAX);
    send_point('0, '0);

    wait_idle();
    apply_config(32'd65535, Q_MAX, Q_MIN);
    send_point(Q_HALF, Q_NEG_TWO);

    run_phase({16'hA5C3, 16'd32}, C_DENDRITE_RE, C_DENDRITE_IM, PACE_FREE, 1'b1);
    run_phase(32'd64, C_SPIRAL_RE, C_SPIRAL_IM, PACE_TX_IDLE, 1'b0);
    run_phase(32'd48, C_DUST_RE, C_DUST_IM, PACE_RX_STALL, 1'b0);
    run_phase(32'd1, rand_in_disk(), rand_in_disk(), PACE_BOTH, 1'b0);
    run_phase(32'd256, C_SWIRL_RE, C_SWIRL_IM, PACE_FREE, 1'b0);
    run_phase($urandom_range(2, 40), $urandom(), $urandom(), PACE_TX_IDLE, 1'b0);
    run_phase(32'd20, Q_TWO, Q_NEG_TWO, PACE_RX_STALL, 1'b0);
    run_phase(32'd16, '0, '0, PACE_BOTH, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d start points (%0d escaped, %0d hit the limit) over %0d settings",
             sb.n_points, sb.n_escaped, sb.n_points - sb.n_escaped, n_settings);
    $display("pacing free, sender gaps, receiver stalls and both, plus a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.n_bad, sb.pending.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
